@@ rtl/protected_path_prefix_guard_defines.svh @@
`ifndef PROTECTED_PATH_PREFIX_GUARD_DEFINES_SVH
`define PROTECTED_PATH_PREFIX_GUARD_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define PPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define PPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ppg_pkg.sv @@
`default_nettype none

package ppg_pkg;

  localparam logic [7:0] SLASH_BYTE = 8'h2F;

  localparam logic CFG_ENFORCE_MODE = 1'b0;
  localparam logic CFG_EXEMPT_PID   = 1'b1;

  localparam int PID_W = 23;

  typedef enum logic [1:0] {
    KIND_PATH_BYTE   = 2'd0,
    KIND_UNRESOLVED  = 2'd1,
    KIND_PREFIX_BYTE = 2'd2,
    KIND_PREFIX_LEN  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_ALLOW   = 2'd0,
    VERDICT_DENY    = 2'd1,
    VERDICT_EARLIER = 2'd2
  } verdict_t;

  // request held in the compare stage
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        byte_value;
    logic              last_byte;
    logic [PID_W-1:0]  caller_pid;
    logic              earlier_denied;
    logic              too_long;
  } req_t;

  // outcome of a finished check, handed to the verdict stage
  typedef struct packed {
    logic              check_end;
    logic              earlier_denied;
    logic              unresolved;
    logic              matched;
    logic [PID_W-1:0]  caller_pid;
  } check_t;

endpackage

`default_nettype wire

@@ rtl/ppg_prefix_mem.sv @@
`default_nettype none

module ppg_prefix_mem #(
  parameter int NUM_PREFIXES = 16,
  parameter int PREFIX_BYTES = 128,
  parameter int AW = 7,
  parameter int LW = 4
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [LW-1:0]               wr_lane,
  input  wire logic [7:0]                  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [NUM_PREFIXES-1:0][7:0] rd_data
);

  // one word per byte position, one byte lane per entry
  logic [NUM_PREFIXES-1:0][7:0] mem [PREFIX_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_lane] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/ppg_match.sv @@
`default_nettype none

module ppg_match
  import ppg_pkg::*;
#(
  parameter int NUM_PREFIXES = 16,
  parameter int PREFIX_BYTES = 128,
  parameter int PW = 13,
  parameter int LW = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         len_wr,
  input  wire logic [LW-1:0]                len_idx,
  input  wire logic [7:0]                   len_value,
  input  wire logic                         fire,
  input  wire req_t                         req,
  input  wire logic [PW-1:0]                pos,
  input  wire logic [NUM_PREFIXES-1:0][7:0] word,
  output check_t                            check
);

  logic [7:0]              lengths [NUM_PREFIXES];
  logic [NUM_PREFIXES-1:0] alive;
  logic [NUM_PREFIXES-1:0] matched;
  logic [NUM_PREFIXES-1:0] alive_next;
  logic [NUM_PREFIXES-1:0] matched_next;
  logic [NUM_PREFIXES-1:0] exact;
  logic                    is_byte;
  logic                    check_end;

  always_comb begin
    logic lv;
    logic p_lt;
    logic p_eq;
    logic p_last;
    for (int e = 0; e < NUM_PREFIXES; e++) begin
      lv     = (lengths[e] != 8'd0) && (32'(lengths[e]) <= PREFIX_BYTES);
      p_lt   = pos < PW'(lengths[e]);
      p_eq   = pos == PW'(lengths[e]);
      p_last = (pos + PW'(1)) == PW'(lengths[e]);
      alive_next[e]   = alive[e] & ~(lv & p_lt & (word[e] != req.byte_value));
      exact[e]        = lv & p_lt & p_last & alive_next[e];
      matched_next[e] = matched[e] |
                        (lv & p_eq & alive[e] & (req.byte_value == SLASH_BYTE));
    end
  end

  assign is_byte   = req.kind == KIND_PATH_BYTE;
  assign check_end = (is_byte && req.last_byte) || (req.kind == KIND_UNRESOLVED);

  assign check.check_end      = check_end;
  assign check.earlier_denied = req.earlier_denied;
  assign check.unresolved     = (req.kind == KIND_UNRESOLVED) || req.too_long;
  assign check.matched        = is_byte && ((|exact) || (|matched_next));
  assign check.caller_pid     = req.caller_pid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NUM_PREFIXES; e++) begin
        lengths[e] <= 8'd0;
      end
    end else if (len_wr) begin
      lengths[len_idx] <= len_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive   <= '1;
      matched <= '0;
    end else if (fire) begin
      if (check_end) begin
        alive   <= '1;
        matched <= '0;
      end else if (is_byte) begin
        alive   <= alive_next;
        matched <= matched_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ppg_verdict.sv @@
`default_nettype none

module ppg_verdict
  import ppg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             enforce_mode,
  input  wire logic [PID_W-1:0] exempt_pid,
  input  wire logic             fire,
  input  wire check_t           check,
  output logic                  slot_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            verdict,
  output logic [63:0]           checks_total,
  output logic [63:0]           denials_total,
  output logic [63:0]           unresolved_total
);

  logic     [63:0] checks_count;
  logic     [63:0] denied_count;
  logic     [63:0] unresolved_count;
  verdict_t        verdict_next;
  logic            count_unres;
  logic            count_deny;
  logic            exempt;

  assign slot_free = !out_valid || out_ready;
  assign exempt    = (exempt_pid != '0) && (check.caller_pid == exempt_pid);

  always_comb begin
    verdict_next = VERDICT_ALLOW;
    count_unres  = 1'b0;
    count_deny   = 1'b0;
    if (check.earlier_denied) begin
      verdict_next = VERDICT_EARLIER;
    end else if (enforce_mode && !exempt) begin
      if (check.unresolved) begin
        count_unres = 1'b1;
      end else if (check.matched) begin
        count_deny   = 1'b1;
        verdict_next = VERDICT_DENY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      checks_count     <= '0;
      denied_count     <= '0;
      unresolved_count <= '0;
    end else begin
      if (fire && check.check_end) begin
        out_valid <= 1'b1;
        if (!check.earlier_denied) begin
          checks_count <= checks_count + 64'd1;
        end
        if (count_unres) begin
          unresolved_count <= unresolved_count + 64'd1;
        end
        if (count_deny) begin
          denied_count <= denied_count + 64'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && check.check_end) begin
      verdict <= verdict_next;
    end
  end

  assign checks_total     = checks_count;
  assign denials_total    = denied_count;
  assign unresolved_total = unresolved_count;

endmodule

`default_nettype wire

@@ rtl/protected_path_prefix_guard.sv @@
// Protected path prefix guard. Takes one request per cycle, unless input is
// stalled: path bytes of a deletion's parent directory, unresolvable-path
// checks, and in-band writes of the prefix table (bytes first, then the
// entry length). Every entry of the table is compared in parallel against
// one word of the prefix memory per path byte. A request is registered in
// the compare stage, and the memory word read for a path byte is registered
// alongside it; the word meets the request there, and the compare stage
// loads the result register directly. A held result stalls input only when
// the compare stage also holds a check-ending request. Prefix memory
// contents are undefined after reset until written; there is no clearing
// pass. Counters wrap at 64 bits.
`default_nettype none

`include "protected_path_prefix_guard_defines.svh"

module protected_path_prefix_guard
  import ppg_pkg::*;
#(
  parameter int NUM_PREFIXES = 16,
  parameter int PREFIX_BYTES = 128,
  parameter int MAX_PATH     = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [22:0]      cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       kind,
  input  wire logic [7:0]       byte_value,
  input  wire logic             last_byte,
  input  wire logic [22:0]      caller_pid,
  input  wire logic             earlier_denied,
  input  wire logic [3:0]       entry_index,
  input  wire logic [6:0]       byte_position,
  input  wire logic [7:0]       prefix_length,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            verdict,
  output logic [63:0]           checks_total,
  output logic [63:0]           denials_total,
  output logic [63:0]           unresolved_total
);

  localparam int AW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam int LW = (NUM_PREFIXES > 1) ? $clog2(NUM_PREFIXES) : 1;
  localparam int PW = $clog2(MAX_PATH + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_PATH);

  logic                         enforce_mode;
  logic [PID_W-1:0]             exempt_pid;
  logic [PW-1:0]                path_position;
  logic [PW-1:0]                pos_next;
  logic                         accept;
  kind_t                        in_kind;
  logic                         in_end;
  logic                         s1_valid;
  req_t                         s1_req;
  logic [PW-1:0]                s1_pos;
  logic                         s1_end;
  logic                         s1_fire;
  logic                         slot_free;
  logic                         lane_ok;
  logic                         addr_ok;
  logic [NUM_PREFIXES-1:0][7:0] word;
  check_t                       check;

  assign in_kind  = kind_t'(kind);
  assign accept   = in_valid && in_ready;
  assign in_end   = ((in_kind == KIND_PATH_BYTE) && last_byte) ||
                    (in_kind == KIND_UNRESOLVED);
  assign pos_next = (path_position < MAX_POS) ? path_position + PW'(1) : path_position;
  assign lane_ok  = 32'(entry_index) < NUM_PREFIXES;
  assign addr_ok  = 32'(byte_position) < PREFIX_BYTES;

  assign s1_end    = ((s1_req.kind == KIND_PATH_BYTE) && s1_req.last_byte) ||
                     (s1_req.kind == KIND_UNRESOLVED);
  assign s1_fire   = s1_valid && (!s1_end || slot_free);
  assign in_ready  = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      enforce_mode <= 1'b0;
      exempt_pid   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ENFORCE_MODE: enforce_mode <= cfg_data[0];
        CFG_EXEMPT_PID:   exempt_pid   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_position <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (in_end) begin
          path_position <= '0;
        end else if (in_kind == KIND_PATH_BYTE) begin
          path_position <= pos_next;
        end
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req.kind           <= in_kind;
      s1_req.byte_value     <= byte_value;
      s1_req.last_byte      <= last_byte;
      s1_req.caller_pid     <= caller_pid;
      s1_req.earlier_denied <= earlier_denied;
      s1_req.too_long       <= pos_next >= MAX_POS;
      s1_pos                <= path_position;
    end
  end

  ppg_prefix_mem #(
    .NUM_PREFIXES(NUM_PREFIXES),
    .PREFIX_BYTES(PREFIX_BYTES),
    .AW(AW),
    .LW(LW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept && (in_kind == KIND_PREFIX_BYTE) && lane_ok && addr_ok),
    .wr_addr (AW'(byte_position)),
    .wr_lane (LW'(entry_index)),
    .wr_data (byte_value),
    .rd_en   (accept && (in_kind == KIND_PATH_BYTE)),
    .rd_addr (AW'(path_position)),
    .rd_data (word)
  );

  ppg_match #(
    .NUM_PREFIXES(NUM_PREFIXES),
    .PREFIX_BYTES(PREFIX_BYTES),
    .PW(PW),
    .LW(LW)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .len_wr    (accept && (in_kind == KIND_PREFIX_LEN) && lane_ok),
    .len_idx   (LW'(entry_index)),
    .len_value (prefix_length),
    .fire      (s1_fire),
    .req       (s1_req),
    .pos       (s1_pos),
    .word      (word),
    .check     (check)
  );

  ppg_verdict u_verdict (
    .clk              (clk),
    .rst              (rst),
    .enforce_mode     (enforce_mode),
    .exempt_pid       (exempt_pid),
    .fire             (s1_fire),
    .check            (check),
    .slot_free        (slot_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .verdict          (verdict),
    .checks_total     (checks_total),
    .denials_total    (denials_total),
    .unresolved_total (unresolved_total)
  );

  `PPG_ASSERT_NOW(a_stall_cause, !in_ready,
    s1_valid && s1_end && out_valid && !out_ready, "input stalled without a held result")
  `PPG_ASSERT_NOW(a_pos_bound, 1'b1, path_position <= MAX_POS, "path position past limit")
  `PPG_ASSERT_NEXT(a_pos_clear, accept && in_end, path_position == '0,
    "path position not cleared at check end")

endmodule

`default_nettype wire
